[hw/rtl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Types and codes shared by the strength sorted table and its cells
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int ID_W   = 16;
    localparam int STR_W  = 32;
    localparam int RANK_W = 6;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int COUNT_OUT_W = 7;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 88;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_RANK  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [STR_W-1:0] strength;
    } entry_t;

    // what each cell hands to its right-hand neighbour
    typedef struct packed {
        entry_t entry;
        logic   less;
    } link_t;

endpackage

[hw/rtl/sst_cell.sv]
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted table: compares, holds, takes new or shifted entry
// ----------------------------------------------------------------------------
module sst_cell
(
    input  logic            clk,
    input  logic            ins_en,
    input  sst_pkg::entry_t new_entry,
    input  logic            occupied,
    input  logic            selected,
    input  sst_pkg::link_t  left,
    output sst_pkg::link_t  right,
    output logic            ge,
    output sst_pkg::entry_t read_data
);

    sst_pkg::entry_t entry_reg;
    sst_pkg::entry_t entry_next;
    logic            less;

    assign less = occupied && (entry_reg.strength < new_entry.strength);
    assign ge   = occupied && !less;

    always_comb
    begin
        entry_next = entry_reg;
        if (ins_en)
        begin
            // at or past the insert point: shift up, the first such slot takes the new one
            if (!left.less)
            begin
                entry_next = left.entry;
            end
            else if (!less)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign right.entry = entry_reg;
    assign right.less  = less;
    assign read_data   = selected ? entry_reg : '0;

endmodule

[hw/rtl/strength_sorted_table.sv]
// ----------------------------------------------------------------------------
// strength_sorted_table
// Sorted (id, strength) table built as a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// output: the result of an accepted request is registered in the output register
// throughput: one unstalled request per cycle; every cell compares against the new strength
// in parallel and shifts in the same cycle, the rank read is a gated or over the row
// reset: asynchronous, clears the entry count, the tracked top id and the output valid;
// cell contents are not cleared and are only read below the count
module strength_sorted_table
#(
    parameter int CAPACITY = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // entry_id[15:0], strength[47:16], rank[53:48], zero pad
    input  logic [sst_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [sst_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_id[15:0], read_strength[47:16], entry_count[54:48],
    // lowest_id[70:55], highest_id[86:71], zero pad
    output logic [sst_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [sst_pkg::STAT_W-1:0]    m_axis_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > sst_pkg::RANK_W) ? CNT_W : sst_pkg::RANK_W;

    logic                          accept;
    logic [sst_pkg::CMD_W-1:0]     command;
    sst_pkg::entry_t               new_entry;
    logic [sst_pkg::RANK_W-1:0]    rank;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [sst_pkg::ID_W-1:0]      high_reg;
    logic [sst_pkg::ID_W-1:0]      high_next;

    logic                          out_valid_reg;
    logic [sst_pkg::M_DATA_W-1:0]  out_data_reg;
    logic [sst_pkg::M_DATA_W-1:0]  out_data_next;
    logic [sst_pkg::STAT_W-1:0]    out_user_reg;
    logic [sst_pkg::STAT_W-1:0]    out_user_next;

    sst_pkg::link_t                link [CAPACITY+1];
    logic [CAPACITY-1:0]           ge_vec;
    sst_pkg::entry_t               cell_read [CAPACITY];
    sst_pkg::entry_t               read_or;

    logic                          is_full;
    logic                          ins_ok;
    logic                          rank_ok;
    logic                          append;
    logic [sst_pkg::ID_W-1:0]      lowest_id;
    logic [sst_pkg::ID_W-1:0]      highest_id;
    logic [sst_pkg::ID_W-1:0]      read_id;
    logic [sst_pkg::STR_W-1:0]     read_strength;

    assign s_axis_tready      = !out_valid_reg || m_axis_tready;
    assign accept             = s_axis_tvalid && s_axis_tready;
    assign command            = s_axis_tuser;
    assign new_entry.id       = s_axis_tdata[15:0];
    assign new_entry.strength = s_axis_tdata[47:16];
    assign rank               = s_axis_tdata[53:48];

    assign is_full = (count_reg >= CNT_W'(CAPACITY));
    assign ins_ok  = accept && (command == sst_pkg::CMD_INSERT) && !is_full;
    assign rank_ok = (CMP_W'(rank) < CMP_W'(count_reg));
    assign append  = !(|ge_vec);

    // cell zero sees a left side that is always below the new entry
    assign link[0].less  = 1'b1;
    assign link[0].entry = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sst_cell u_cell
        (
            .clk       (clk),
            .ins_en    (ins_ok),
            .new_entry (new_entry),
            .occupied  (CNT_W'(i) < count_reg),
            .selected  (CMP_W'(rank) == CMP_W'(i)),
            .left      (link[i]),
            .right     (link[i+1]),
            .ge        (ge_vec[i]),
            .read_data (cell_read[i])
        );
    end

    always_comb
    begin
        read_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            read_or = read_or | cell_read[i];
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        high_next     = high_reg;
        out_user_next = sst_pkg::STAT_OK;
        read_id       = '0;
        read_strength = '0;
        case (command)
            sst_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            sst_pkg::CMD_INSERT:
            begin
                if (is_full)
                begin
                    out_user_next = sst_pkg::STAT_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    // top id only moves when the new entry lands past every held one
                    if (append)
                    begin
                        high_next = new_entry.id;
                    end
                end
            end
            sst_pkg::CMD_READ:
            begin
                if (rank_ok)
                begin
                    read_id       = read_or.id;
                    read_strength = read_or.strength;
                end
                else
                begin
                    out_user_next = sst_pkg::STAT_NO_RANK;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        if (count_next == '0)
        begin
            lowest_id  = '0;
            highest_id = '0;
        end
        else
        begin
            lowest_id  = (ins_ok && !link[1].less) ? new_entry.id : link[1].entry.id;
            highest_id = high_next;
        end
    end

    assign out_data_next = {1'b0, highest_id, lowest_id,
                            sst_pkg::COUNT_OUT_W'(count_next), read_strength, read_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                high_reg      <= high_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
